### design/text_console_cursor_engine_core_macros.svh
// Assertion shorthands used by the checker of the console core.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_CORE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define TCCE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcce: same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcce: next-cycle check failed");

`endif

### design/tcce_pkg.sv
package tcce_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int SHIFTED    = (ROWS - 1) * COLUMNS;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int PTR_W  = $clog2(CELL_COUNT + 1);
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ROW_W  = $clog2(ROWS + 1);

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Character codes
    localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [7:0] CHAR_TAB       = 8'd9;
    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;

    localparam int TAB_STOP = 4;

    // Register indexes
    localparam logic CFG_TEXT_COLOR  = 1'b0;
    localparam logic CFG_BLANK_COLOR = 1'b1;

    localparam logic [7:0] TEXT_COLOR_RESET  = 8'd15;
    localparam logic [7:0] BLANK_COLOR_RESET = 8'd0;
    localparam logic [15:0] INIT_CELL        = {8'd0, CHAR_SPACE};

    typedef enum logic [1:0] {
        KIND_PUT   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        OP_PUT_CHAR,
        OP_NEWLINE,
        OP_TAB,
        OP_BACKSPACE,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [7:0]        char_code;
        logic [ADDR_W-1:0] addr;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL,
        ST_FILL,
        ST_DONE
    } t_state;

endpackage

### design/tcce_front.sv
module tcce_front (
    input  logic                 i_valid,
    input  logic [1:0]           i_kind,
    input  logic [7:0]           i_char_code,
    input  logic [10:0]          i_cell_index,
    input  logic                 i_queue_full,
    input  logic                 i_init_done,
    output logic                 o_ready,
    output logic                 o_push,
    output tcce_pkg::t_cmd       o_cmd
);

    // Take words only once the screen is initialised and the queue has room.
    assign o_ready = i_init_done && !i_queue_full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_cmd.char_code = i_char_code;
        // saturate the read index to the last cell
        if (32'(i_cell_index) >= tcce_pkg::CELL_COUNT) begin
            o_cmd.addr = tcce_pkg::ADDR_W'(tcce_pkg::CELL_COUNT - 1);
        end else begin
            o_cmd.addr = tcce_pkg::ADDR_W'(i_cell_index);
        end
        unique case (i_kind)
            tcce_pkg::KIND_PUT: begin
                unique case (i_char_code)
                    tcce_pkg::CHAR_NEWLINE:   o_cmd.op = tcce_pkg::OP_NEWLINE;
                    tcce_pkg::CHAR_TAB:       o_cmd.op = tcce_pkg::OP_TAB;
                    tcce_pkg::CHAR_BACKSPACE: o_cmd.op = tcce_pkg::OP_BACKSPACE;
                    default:                  o_cmd.op = tcce_pkg::OP_PUT_CHAR;
                endcase
            end
            tcce_pkg::KIND_CLEAR: o_cmd.op = tcce_pkg::OP_CLEAR;
            tcce_pkg::KIND_READ:  o_cmd.op = tcce_pkg::OP_READ;
            default:              o_cmd.op = tcce_pkg::OP_NOP;
        endcase
    end

endmodule

### design/tcce_queue.sv
module tcce_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcce_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output tcce_pkg::t_cmd o_cmd
);

    tcce_pkg::t_cmd r_slot [tcce_pkg::QDEPTH];

    logic [tcce_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [tcce_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [tcce_pkg::QCNT_W-1:0] r_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == tcce_pkg::QCNT_W'(tcce_pkg::QDEPTH));
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### design/tcce_back.sv
module tcce_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic [7:0]     i_cfg_data,
    input  logic           i_cmd_valid,
    input  tcce_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_init_done,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [39:0]    o_out_data
);

    localparam int ADDR_W = tcce_pkg::ADDR_W;
    localparam int PTR_W  = tcce_pkg::PTR_W;
    localparam int COL_W  = tcce_pkg::COL_W;
    localparam int ROW_W  = tcce_pkg::ROW_W;

    logic [15:0] mem [tcce_pkg::CELL_COUNT];

    tcce_pkg::t_state   r_state, n_state;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [PTR_W-1:0]   r_ptr, n_ptr;
    logic               r_scrolled, n_scrolled;
    logic               r_is_read, n_is_read;
    logic [7:0]         r_text, n_text;
    logic [7:0]         r_blank, n_blank;
    logic               r_ovalid, n_ovalid;
    logic [39:0]        r_odata, n_odata;
    logic [15:0]        r_rdata;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [15:0]        mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;

    logic [ADDR_W-1:0]  loc_full;
    logic [ADDR_W-1:0]  cur_addr;
    logic [ADDR_W-1:0]  bs_addr;
    logic [COL_W:0]     raw_col;
    logic [ROW_W:0]     raw_row;
    logic [COL_W-1:0]   mv_col;
    logic [ROW_W:0]     mv_row;
    logic               mv_scroll;
    logic               out_free;

    assign o_cmd_pop   = (r_state == tcce_pkg::ST_IDLE) && i_cmd_valid;
    assign o_init_done = (r_state != tcce_pkg::ST_INIT);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
    assign out_free    = !r_ovalid || i_out_ready;

    assign loc_full = ADDR_W'(32'(r_row) * 32'(tcce_pkg::COLUMNS) + 32'(r_col));
    assign cur_addr = loc_full;
    assign bs_addr  = (cur_addr == '0) ? '0 : cur_addr - 1'b1;

    // Raw cursor move for the put family, before wrap and scroll.
    always_comb begin
        raw_col = {1'b0, r_col};
        raw_row = {1'b0, r_row};
        case (i_cmd.op)
            tcce_pkg::OP_PUT_CHAR: raw_col = {1'b0, r_col} + 1'b1;
            tcce_pkg::OP_NEWLINE: begin
                raw_col = '0;
                raw_row = {1'b0, r_row} + 1'b1;
            end
            tcce_pkg::OP_TAB: begin
                raw_col = {1'b0, r_col[COL_W-1:2], 2'b00} + (COL_W+1)'(tcce_pkg::TAB_STOP);
            end
            tcce_pkg::OP_BACKSPACE: begin
                if (r_col != '0) begin
                    raw_col = {1'b0, r_col} - 1'b1;
                end else if (r_row != '0) begin
                    raw_col = (COL_W+1)'(tcce_pkg::COLUMNS - 1);
                    raw_row = {1'b0, r_row} - 1'b1;
                end
            end
            default: ;
        endcase
        // wrap the column, then check for a scroll
        if (32'(raw_col) >= tcce_pkg::COLUMNS) begin
            mv_col = '0;
            mv_row = raw_row + 1'b1;
        end else begin
            mv_col = COL_W'(raw_col);
            mv_row = raw_row;
        end
        mv_scroll = (32'(mv_row) >= tcce_pkg::ROWS);
    end

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_ptr      = r_ptr;
        n_scrolled = r_scrolled;
        n_is_read  = r_is_read;
        n_text     = r_text;
        n_blank    = r_blank;
        n_ovalid   = r_ovalid && !i_out_ready;
        n_odata    = r_odata;
        mem_we     = 1'b0;
        mem_waddr  = cur_addr;
        mem_wdata  = {r_text, i_cmd.char_code};
        mem_re     = 1'b0;
        mem_raddr  = i_cmd.addr;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                tcce_pkg::CFG_TEXT_COLOR:  n_text  = i_cfg_data;
                tcce_pkg::CFG_BLANK_COLOR: n_blank = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            tcce_pkg::ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr[ADDR_W-1:0];
                mem_wdata = tcce_pkg::INIT_CELL;
                if (r_ptr == PTR_W'(tcce_pkg::CELL_COUNT - 1)) begin
                    n_ptr   = '0;
                    n_state = tcce_pkg::ST_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            tcce_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_scrolled = 1'b0;
                    n_is_read  = 1'b0;
                    n_state    = tcce_pkg::ST_DONE;
                    case (i_cmd.op)
                        tcce_pkg::OP_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_ptr   = '0;
                            n_state = tcce_pkg::ST_FILL;
                        end
                        tcce_pkg::OP_READ: begin
                            mem_re    = 1'b1;
                            n_is_read = 1'b1;
                        end
                        tcce_pkg::OP_NOP: ;
                        default: begin
                            // write the cell for put and backspace, then move the cursor
                            if (i_cmd.op == tcce_pkg::OP_PUT_CHAR) begin
                                mem_we = 1'b1;
                            end else if (i_cmd.op == tcce_pkg::OP_BACKSPACE) begin
                                mem_we    = 1'b1;
                                mem_waddr = bs_addr;
                                mem_wdata = {r_text, tcce_pkg::CHAR_SPACE};
                            end
                            if (mv_scroll) begin
                                n_col      = '0;
                                n_row      = ROW_W'(tcce_pkg::ROWS - 1);
                                n_scrolled = 1'b1;
                                n_ptr      = PTR_W'(tcce_pkg::COLUMNS);
                                n_state    = tcce_pkg::ST_SCROLL;
                            end else begin
                                n_col = mv_col;
                                n_row = ROW_W'(mv_row);
                            end
                        end
                    endcase
                end
            end
            tcce_pkg::ST_SCROLL: begin
                // read one row ahead, write what came back in the next cycle
                if (r_ptr < PTR_W'(tcce_pkg::CELL_COUNT)) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_ptr[ADDR_W-1:0];
                end
                if (r_ptr > PTR_W'(tcce_pkg::COLUMNS)) begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(r_ptr - PTR_W'(tcce_pkg::COLUMNS + 1));
                    mem_wdata = r_rdata;
                end
                if (r_ptr == PTR_W'(tcce_pkg::CELL_COUNT)) begin
                    n_ptr   = PTR_W'(tcce_pkg::SHIFTED);
                    n_state = tcce_pkg::ST_FILL;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            tcce_pkg::ST_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr[ADDR_W-1:0];
                mem_wdata = {r_blank, tcce_pkg::CHAR_SPACE};
                if (r_ptr == PTR_W'(tcce_pkg::CELL_COUNT - 1)) begin
                    n_state = tcce_pkg::ST_DONE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            tcce_pkg::ST_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = {r_scrolled,
                                r_is_read ? r_rdata : 16'd0,
                                loc_full,
                                5'(r_row),
                                7'(r_col)};
                    n_state  = tcce_pkg::ST_IDLE;
                end
            end
            default: n_state = tcce_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tcce_pkg::ST_INIT;
            r_col      <= '0;
            r_row      <= '0;
            r_ptr      <= '0;
            r_scrolled <= 1'b0;
            r_is_read  <= 1'b0;
            r_text     <= tcce_pkg::TEXT_COLOR_RESET;
            r_blank    <= tcce_pkg::BLANK_COLOR_RESET;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_ptr      <= n_ptr;
            r_scrolled <= n_scrolled;
            r_is_read  <= n_is_read;
            r_text     <= n_text;
            r_blank    <= n_blank;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_odata <= n_odata;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

endmodule

### design/text_console_cursor_engine_core.sv
// Put, newline, tab, backspace, read and unused kinds: the back pops the queue head while idle
// and sends the result word from its done state; it takes one word at a time.
// A scroll copies the rows up and blanks the bottom row, and a clear blanks every cell,
// both through the single-write-port screen memory, one cell per cycle.
// Synchronous active-low reset; afterwards a pass blanks the screen to 0x0020
// and no input word is taken until it ends. Configuration writes are taken throughout.
module text_console_cursor_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [7:0] char_code, [18:8] cell_index, rest zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] kind
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // [6:0] cursor_column, [11:7] cursor_row,
                                          // [22:12] cursor_linear, [38:23] cell_value,
                                          // [39] scrolled
);

    tcce_pkg::t_cmd front_cmd;
    tcce_pkg::t_cmd queue_cmd;
    logic           front_push;
    logic           queue_full;
    logic           queue_valid;
    logic           back_pop;
    logic           init_done;

    // Front: classify the word (control characters, saturated read index) and queue it.
    tcce_front u_front (
        .i_valid      (i_s_axis_tvalid),
        .i_kind       (i_s_axis_tuser),
        .i_char_code  (i_s_axis_tdata[7:0]),
        .i_cell_index (i_s_axis_tdata[18:8]),
        .i_queue_full (queue_full),
        .i_init_done  (init_done),
        .o_ready      (o_s_axis_tready),
        .o_push       (front_push),
        .o_cmd        (front_cmd)
    );

    // Short command queue: lets the front keep taking words while the back walks the screen.
    tcce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_full  (queue_full),
        .o_cmd   (queue_cmd)
    );

    // Back: cursor state, screen memory, scroll/clear sequencer and the result register.
    tcce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (back_pop),
        .o_init_done (init_done),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

### design/tcce_checker.sv
`include "text_console_cursor_engine_core_macros.svh"

module tcce_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata
);

    logic [6:0]  rpt_col;
    logic [4:0]  rpt_row;
    logic [10:0] rpt_loc;
    logic        rpt_scroll;

    assign rpt_col    = o_m_axis_tdata[6:0];
    assign rpt_row    = o_m_axis_tdata[11:7];
    assign rpt_loc    = o_m_axis_tdata[22:12];
    assign rpt_scroll = o_m_axis_tdata[39];

    // cursor always on the screen
    `TCCE_ASSERT_NOW(a_cursor_on_screen, i_clk, i_rst_n, o_m_axis_tvalid, (32'(rpt_col) < tcce_pkg::COLUMNS) && (32'(rpt_row) < tcce_pkg::ROWS))

    // linear location agrees with column and row
    `TCCE_ASSERT_NOW(a_location_match, i_clk, i_rst_n, o_m_axis_tvalid, rpt_loc == 11'(32'(rpt_row) * tcce_pkg::COLUMNS + 32'(rpt_col)))

    // a scroll leaves the cursor at the start of the bottom row
    `TCCE_ASSERT_NOW(a_scroll_home, i_clk, i_rst_n, o_m_axis_tvalid && rpt_scroll, (rpt_col == 7'd0) && (32'(rpt_row) == tcce_pkg::ROWS - 1))

    // a stalled result word holds
    `TCCE_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

endmodule

bind text_console_cursor_engine_core tcce_checker u_tcce_checker (.*);

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         TAIL_CYCLES   = 64;
    localparam int         HOLD_CYCLES   = 300;
    // Worst case: every word a scroll plus the longest gap on each side, taken about four times.
    localparam longint     TIMEOUT_NS    = 200_000_000;

    // Result word as it leaves the block, lowest field in the lowest bits.
    typedef struct packed {
        logic        scrolled;
        logic [15:0] cell_val;
        logic [10:0] loc;
        logic [4:0]  row;
        logic [6:0]  col;
    } t_cursor_report;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = tcce_pkg::CFG_TEXT_COLOR;
    logic [7:0]  cfg_data = 8'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [23:0] in_data = 24'd0;
    logic [1:0]  in_kind = tcce_pkg::KIND_PUT;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [39:0] out_data;

    // Mirror of the console: screen contents, cursor and colour registers.
    logic [15:0] screen_image [tcce_pkg::CELL_COUNT];
    int          cur_col;
    int          cur_row;
    logic [7:0]  text_attr;
    logic [7:0]  blank_attr;

    t_cursor_report cursor_reports [$];
    int             errors = 0;
    bit             send_idle = 1'b1;
    bit             drain_idle = 1'b1;
    int             hold_left = 0;

    text_console_cursor_engine_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tuser  (in_kind),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Console mirror
    // ------------------------------------------------------------------

    function automatic void home_console();
        for (int i = 0; i < tcce_pkg::CELL_COUNT; i++) begin
            screen_image[i] = tcce_pkg::INIT_CELL;
        end
        cur_col    = 0;
        cur_row    = 0;
        text_attr  = tcce_pkg::TEXT_COLOR_RESET;
        blank_attr = tcce_pkg::BLANK_COLOR_RESET;
    endfunction

    function automatic int cursor_cell();
        int idx;
        idx = cur_row * tcce_pkg::COLUMNS + cur_col;
        if (idx >= tcce_pkg::CELL_COUNT) begin
            idx = tcce_pkg::CELL_COUNT - 1;
        end
        return idx;
    endfunction

    function automatic void blank_cells(int from);
        for (int i = from; i < tcce_pkg::CELL_COUNT; i++) begin
            screen_image[i] = {blank_attr, tcce_pkg::CHAR_SPACE};
        end
    endfunction

    // Interpret one character; return 1 when the screen rolled up a row.
    function automatic bit put_glyph(logic [7:0] ch);
        bit rolled;
        rolled = 1'b0;
        case (ch)
            tcce_pkg::CHAR_NEWLINE: begin
                cur_row++;
                cur_col = 0;
            end
            tcce_pkg::CHAR_TAB: begin
                cur_col += tcce_pkg::TAB_STOP - (cur_col % tcce_pkg::TAB_STOP);
            end
            tcce_pkg::CHAR_BACKSPACE: begin
                // step back, wrap to the end of the previous row, stay put at the origin
                if (cur_col > 0) begin
                    cur_col--;
                end else if (cur_row > 0) begin
                    cur_col = tcce_pkg::COLUMNS - 1;
                    cur_row--;
                end
                screen_image[cursor_cell()] = {text_attr, tcce_pkg::CHAR_SPACE};
            end
            default: begin
                screen_image[cursor_cell()] = {text_attr, ch};
                cur_col++;
            end
        endcase
        if (cur_col >= tcce_pkg::COLUMNS) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= tcce_pkg::ROWS) begin
            // move every row up one and bring in a blank bottom row
            for (int i = 0; i < tcce_pkg::SHIFTED; i++) begin
                screen_image[i] = screen_image[i + tcce_pkg::COLUMNS];
            end
            blank_cells(tcce_pkg::SHIFTED);
            cur_col = 0;
            cur_row = tcce_pkg::ROWS - 1;
            rolled  = 1'b1;
        end
        return rolled;
    endfunction

    function automatic t_cursor_report console_step(logic [1:0] kind, logic [7:0] ch,
                                                   logic [10:0] idx);
        t_cursor_report rep;
        int             cell_idx;
        rep = '0;
        case (kind)
            tcce_pkg::KIND_PUT: begin
                rep.scrolled = put_glyph(ch);
            end
            tcce_pkg::KIND_CLEAR: begin
                blank_cells(0);
                cur_col = 0;
                cur_row = 0;
            end
            tcce_pkg::KIND_READ: begin
                // saturate reads beyond the screen to the last cell
                cell_idx = (idx >= tcce_pkg::CELL_COUNT) ? tcce_pkg::CELL_COUNT - 1 : int'(idx);
                rep.cell_val = screen_image[cell_idx];
            end
            default: begin
                // unused kind: report the cursor and change nothing
            end
        endcase
        rep.col = cur_col[6:0];
        rep.row = cur_row[4:0];
        rep.loc = 11'(cur_row * tcce_pkg::COLUMNS + cur_col);
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Offer one word, hold it until taken, then predict its report.
    task automatic send_word(input logic [1:0] kind, input logic [7:0] ch,
                             input logic [10:0] idx);
        int gap;
        gap = send_idle ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_kind  <= kind;
        in_data  <= {5'd0, idx, ch};
        do @(posedge i_clk); while (!in_ready);
        cursor_reports.push_back(console_step(kind, ch, idx));
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_word(tcce_pkg::KIND_PUT, ch, 11'd0);
    endtask

    task automatic read_cell(input int idx);
        send_word(tcce_pkg::KIND_READ, 8'd0, 11'(idx));
    endtask

    // Drop valid and wait for the block to drain before touching registers.
    task automatic settle();
        in_valid <= 1'b0;
        while (cursor_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Pulse the write enable for one edge, then idle before the next write.
    task automatic write_colour(input logic index, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        if (index == tcce_pkg::CFG_TEXT_COLOR) begin
            text_attr = value;
        end else begin
            blank_attr = value;
        end
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, the long hold-off and the checker
    // ------------------------------------------------------------------

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (drain_idle && stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready  <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, name, want, want, got, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_cursor_report want;
        t_cursor_report got;
        if (rst_n && out_valid && out_ready) begin
            got = out_data;
            if (cursor_reports.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual 0x%0h",
                         $time, out_data);
                errors++;
            end else begin
                want = cursor_reports.pop_front();
                check_field("cursor_column", want.col, got.col);
                check_field("cursor_row", want.row, got.row);
                check_field("cursor_linear", want.loc, got.loc);
                check_field("cell_value", want.cell_val, got.cell_val);
                check_field("scrolled", want.scrolled, got.scrolled);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset contents, saturating reads, the unused kind, wraps and backspace corners.
    task automatic test_edge_cases();
        read_cell(0);
        read_cell(tcce_pkg::CELL_COUNT - 1);
        read_cell(2047);
        send_word(KIND_UNUSED, 8'hFF, 11'h7FF);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(tcce_pkg::CHAR_TAB);
        put_char(tcce_pkg::CHAR_BACKSPACE);
        read_cell(3);
        put_char(tcce_pkg::CHAR_NEWLINE);
        put_char(tcce_pkg::CHAR_BACKSPACE);   // wraps to the last column of row 0
        put_char(8'h41);                      // written in the last column, wraps
        read_cell(tcce_pkg::COLUMNS - 1);
        put_char(tcce_pkg::CHAR_BACKSPACE);
        put_char(tcce_pkg::CHAR_TAB);         // tab from the last column wraps
        send_word(tcce_pkg::KIND_CLEAR, 8'h55, 11'h2AA);
        put_char(tcce_pkg::CHAR_BACKSPACE);   // at the origin the cursor stays
        read_cell(0);
        read_cell(1);
        put_char(8'h41);
    endtask

    // Walk the cursor to the bottom and roll the screen once.
    task automatic test_scroll();
        put_char(8'h52);
        repeat (tcce_pkg::ROWS - 1) put_char(tcce_pkg::CHAR_NEWLINE);
        put_char(8'h51);
        put_char(tcce_pkg::CHAR_NEWLINE);
        read_cell(0);
        read_cell(tcce_pkg::SHIFTED - tcce_pkg::COLUMNS);
        read_cell(tcce_pkg::CELL_COUNT - 1);
    endtask

    // Colour registers at their extremes, each seen through writes, blanks and reads.
    task automatic test_colours();
        logic [7:0] text_v [2];
        logic [7:0] blank_v [2];
        text_v  = '{8'hFF, 8'h00};
        blank_v = '{8'h00, 8'hFF};
        for (int p = 0; p < 2; p++) begin
            settle();
            write_colour(tcce_pkg::CFG_TEXT_COLOR, text_v[p]);
            write_colour(tcce_pkg::CFG_BLANK_COLOR, blank_v[p]);
            put_char(8'h5A);
            put_char(tcce_pkg::CHAR_BACKSPACE);
            put_char(8'h7E);
            read_cell(0);
            read_cell(1);
            send_word(tcce_pkg::KIND_CLEAR, 8'h00, 11'd0);
            read_cell(tcce_pkg::CELL_COUNT - 1);
        end
    endtask

    // Stop taking results for a long stretch while words keep coming.
    task automatic test_backpressure();
        settle();
        send_idle = 1'b0;
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 40; i++) begin
            if (i % 3 == 0) begin
                read_cell($urandom_range(0, 2047));
            end else begin
                put_char(8'($urandom_range(32, 126)));
            end
        end
        send_idle = 1'b1;
    endtask

    task automatic send_random_word();
        int r;
        int near;
        r = $urandom_range(0, 99);
        if (r < 1) begin
            send_word(tcce_pkg::KIND_CLEAR, 8'($urandom), 11'($urandom));
        end else if (r < 3) begin
            send_word(KIND_UNUSED, 8'($urandom), 11'($urandom));
        end else if (r < 33) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                // around the cursor, where the latest writes landed
                near = cur_row * tcce_pkg::COLUMNS + cur_col + $urandom_range(0, 8) - 6;
                read_cell(near < 0 ? 0 : near);
            end else if (r < 80) begin
                read_cell($urandom_range(0, tcce_pkg::CELL_COUNT - 1));
            end else if (r < 90) begin
                read_cell($urandom_range(tcce_pkg::CELL_COUNT, 2047));
            end else begin
                send_word(tcce_pkg::KIND_READ, 8'($urandom), 11'($urandom));
            end
        end else begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                put_char(tcce_pkg::CHAR_NEWLINE);
            end else if (r < 12) begin
                put_char(tcce_pkg::CHAR_TAB);
            end else if (r < 20) begin
                put_char(tcce_pkg::CHAR_BACKSPACE);
            end else begin
                put_char(8'($urandom));
            end
        end
    endtask

    // Several phases, each with fresh colours; some without any idling.
    task automatic test_random_traffic(input int phases, input int words_per_phase);
        for (int p = 0; p < phases; p++) begin
            settle();
            case (p % 3)
                0: begin
                    write_colour(tcce_pkg::CFG_TEXT_COLOR, 8'($urandom));
                    write_colour(tcce_pkg::CFG_BLANK_COLOR, 8'($urandom));
                end
                1: begin
                    write_colour(tcce_pkg::CFG_TEXT_COLOR, 8'h00);
                    write_colour(tcce_pkg::CFG_BLANK_COLOR, 8'hFF);
                end
                default: begin
                    write_colour(tcce_pkg::CFG_BLANK_COLOR, 8'h00);
                    write_colour(tcce_pkg::CFG_TEXT_COLOR, 8'hFF);
                end
            endcase
            send_idle  = (p % 4 != 3);
            drain_idle = (p % 4 != 3);
            repeat (words_per_phase) send_random_word();
        end
        send_idle  = 1'b1;
        drain_idle = 1'b1;
    endtask

    initial begin
        home_console();
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        test_edge_cases();
        test_scroll();
        test_colours();
        test_backpressure();
        test_random_traffic(6, 300);
        in_valid <= 1'b0;
        while (cursor_reports.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("testbench: FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/tcce_pkg.sv
design/tcce_front.sv
design/tcce_queue.sv
design/tcce_back.sv
design/text_console_cursor_engine_core.sv
design/tcce_checker.sv
sim/testbench.sv
